// ===== sv/upp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upp_pkg: shared types and constants of the unicycle pose predictor
// Holds the CORDIC angle table, range limits and the cell payload struct.
// ----------------------------------------------------------------------------
package upp_pkg;

	localparam int CordicStages = 16;
	localparam int AtanEntries  = 30;
	localparam int StageW       = $clog2(AtanEntries);

	localparam logic signed [19:0] TwoPiQ16  = 20'sd411775;
	localparam logic signed [19:0] PiQ16     = 20'sd205887;
	localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
	localparam logic signed [33:0] GainQ30   = 34'sh026DD3B6A;

	// floor(2^40 / TwoPiQ16), quotient estimate for the heading reduction
	localparam logic signed [23:0] RecipTwoPiQ40 = 24'sd2670175;

	// Q30 CORDIC data: |x|,|y| < 2^31, z fits 34 bits
	localparam int CW = 34;

	typedef logic signed [CW-1:0] cw_t;

	function automatic cw_t atan_q30(input logic [StageW-1:0] i);
		cw_t r;
		case (i)
			5'd0:  r = 34'sh03243F6A8;
			5'd1:  r = 34'sh01DAC6705;
			5'd2:  r = 34'sh00FADBAFC;
			5'd3:  r = 34'sh007F56EA6;
			5'd4:  r = 34'sh003FEAB76;
			5'd5:  r = 34'sh001FFD55B;
			5'd6:  r = 34'sh000FFFAAA;
			5'd7:  r = 34'sh0007FFF55;
			5'd8:  r = 34'sh0003FFFEA;
			5'd9:  r = 34'sh0001FFFFD;
			5'd10: r = 34'sh0000FFFFF;
			5'd11: r = 34'sh00007FFFF;
			5'd12: r = 34'sh00003FFFF;
			5'd13: r = 34'sh00001FFFF;
			5'd14: r = 34'sh00000FFFF;
			5'd15: r = 34'sh000007FFF;
			5'd16: r = 34'sh000003FFF;
			5'd17: r = 34'sh000001FFF;
			5'd18: r = 34'sh000000FFF;
			5'd19: r = 34'sh0000007FF;
			5'd20: r = 34'sh0000003FF;
			5'd21: r = 34'sh0000001FF;
			5'd22: r = 34'sh0000000FF;
			5'd23: r = 34'sh00000007F;
			5'd24: r = 34'sh00000003F;
			5'd25: r = 34'sh00000001F;
			5'd26: r = 34'sh00000000F;
			5'd27: r = 34'sh000000008;
			5'd28: r = 34'sh000000004;
			5'd29: r = 34'sh000000002;
			default: r = '0;
		endcase
		return r;
	endfunction

	// side data that rides along the cell chain
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] th;
		logic        [31:0] mag_v;
		logic               neg_v;
		logic        [23:0] dt;
		logic signed [40:0] hstep;
		logic        [31:0] nspeed;
		logic        [31:0] nturn;
		logic               flip;
	} side_t;

	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
	} rot_t;

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh07FFFFFFF) return 32'h7FFFFFFF;
		if (v < -34'sh080000000) return 32'h80000000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/upp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upp_cell: one CORDIC rotation cell
// Rotates by the table angle of its stage and hands the vector on.
// ----------------------------------------------------------------------------
module upp_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic [upp_pkg::StageW-1:0]   stage,
	input  wire logic                         vld_in,
	input  upp_pkg::rot_t                     rot_in,
	input  upp_pkg::side_t                    side_in,
	output logic                              vld_q,
	output upp_pkg::rot_t                     rot_q,
	output upp_pkg::side_t                    side_q
);
	upp_pkg::cw_t dx, dy, a;
	upp_pkg::rot_t nxt;

	always_comb begin
		dx = rot_in.y >>> stage;
		dy = rot_in.x >>> stage;
		a  = upp_pkg::atan_q30(stage);
		if (!rot_in.z[upp_pkg::CW-1]) begin
			nxt.x = rot_in.x - dx;
			nxt.y = rot_in.y + dy;
			nxt.z = rot_in.z - a;
		end else begin
			nxt.x = rot_in.x + dx;
			nxt.y = rot_in.y - dy;
			nxt.z = rot_in.z + a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q  <= nxt;
			side_q <= side_in;
		end
	end
endmodule
`default_nettype wire

// ===== sv/upp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upp_front: heading reduction and heading step
// Reduces heading into [-pi/2, pi/2] and forms the rounded turn step.
// ----------------------------------------------------------------------------
module upp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_in,
	input  wire logic [248:0]        req,
	output logic                     vld_q,
	output upp_pkg::rot_t            rot_q,
	output upp_pkg::side_t           side_q
);
	logic signed [31:0] px, py, th, v, w, cs, ct;
	logic        [23:0] dt;
	logic               cv;
	logic        [31:0] wmag, vmag;
	// stage 1 registers
	logic signed [55:0] qp_s1;
	logic        [55:0] hprod_s1;
	logic               wneg_s1, vld_s1;
	upp_pkg::side_t     side_s1;
	// stage 2 registers
	logic signed [20:0] rem_s2;
	logic               vld_s2;
	upp_pkg::side_t     side_s2;
	// stage 2 and 3 logic
	logic signed [14:0] quo;
	logic signed [35:0] qd, rraw;
	logic        [40:0] hr;
	upp_pkg::side_t     side_h, side_o;
	logic signed [20:0] r0, r1, r2;
	logic               fl;

	assign px = req[31:0];
	assign py = req[63:32];
	assign th = req[95:64];
	assign v  = req[127:96];
	assign w  = req[159:128];
	assign dt = req[183:160];
	assign cv = req[184];
	assign cs = req[216:185];
	assign ct = req[248:217];

	always_comb begin
		wmag = w[31] ? 32'(-w) : w;
		vmag = v[31] ? 32'(-v) : v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qp_s1          <= th * upp_pkg::RecipTwoPiQ40;
			hprod_s1       <= wmag * dt;
			wneg_s1        <= w[31];
			side_s1.px     <= px;
			side_s1.py     <= py;
			side_s1.th     <= th;
			side_s1.mag_v  <= vmag;
			side_s1.neg_v  <= v[31];
			side_s1.dt     <= dt;
			side_s1.hstep  <= '0;
			side_s1.nspeed <= cv ? cs : v;
			side_s1.nturn  <= cv ? ct : w;
			side_s1.flip   <= 1'b0;
		end
	end

	// quotient estimate is floor or one off, so the raw remainder is in [-2pi, 4pi)
	always_comb begin
		quo  = qp_s1[54:40];
		qd   = 36'(quo) * 36'(upp_pkg::TwoPiQ16);
		rraw = 36'(side_s1.th) - qd;
		hr   = 41'((hprod_s1 + 56'd32768) >> 16);
		side_h       = side_s1;
		side_h.hstep = wneg_s1 ? -41'(hr) : 41'(hr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= 21'(rraw);
			side_s2 <= side_h;
		end
	end

	always_comb begin
		r0 = rem_s2;
		if (r0 < 0) r0 = r0 + 21'(upp_pkg::TwoPiQ16);
		else if (r0 >= 21'(upp_pkg::TwoPiQ16)) r0 = r0 - 21'(upp_pkg::TwoPiQ16);
		r1 = r0;
		if (r1 > 21'(upp_pkg::PiQ16)) r1 = r1 - 21'(upp_pkg::TwoPiQ16);
		fl = 1'b0;
		r2 = r1;
		if (r1 > 21'(upp_pkg::HalfPiQ16)) begin
			r2 = r1 - 21'(upp_pkg::PiQ16);
			fl = 1'b1;
		end else if (r1 < -21'(upp_pkg::HalfPiQ16)) begin
			r2 = r1 + 21'(upp_pkg::PiQ16);
			fl = 1'b1;
		end
		side_o      = side_s2;
		side_o.flip = fl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q.x <= upp_pkg::GainQ30;
			rot_q.y <= '0;
			rot_q.z <= upp_pkg::cw_t'(r2) <<< 14;
			side_q  <= side_o;
		end
	end
endmodule
`default_nettype wire

// ===== sv/upp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upp_back: displacement and final sums
// Scales cosine and sine by speed and step, rounds, adds and saturates.
// ----------------------------------------------------------------------------
module upp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vld_in,
	input  upp_pkg::rot_t        rot_in,
	input  upp_pkg::side_t       side_in,
	output logic                 vld_q,
	output logic [159:0]         res_q
);
	upp_pkg::cw_t c, s;
	logic [31:0] cm, sm;
	// stage 1: a = |v|*dt, trig magnitudes
	logic [55:0] a_s1;
	logic [31:0] cm_s1, sm_s1;
	logic        nc_s1, ns_s1, v1_s1;
	upp_pkg::side_t sd_s1;
	// stage 2: partial products
	logic [55:0] ch_s2, sh_s2;
	logic [63:0] cl_s2, sl_s2;
	logic        nc_s2, ns_s2, v2_s2;
	upp_pkg::side_t sd_s2;

	always_comb begin
		c = side_in.flip ? -rot_in.x : rot_in.x;
		s = side_in.flip ? -rot_in.y : rot_in.y;
		cm = 32'(c[upp_pkg::CW-1] ? -c : c);
		sm = 32'(s[upp_pkg::CW-1] ? -s : s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			v1_s1 <= vld_in;
			v2_s2 <= v1_s1;
			vld_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= side_in.mag_v * side_in.dt;
			cm_s1 <= cm;
			sm_s1 <= sm;
			nc_s1 <= side_in.neg_v ^ c[upp_pkg::CW-1];
			ns_s1 <= side_in.neg_v ^ s[upp_pkg::CW-1];
			sd_s1 <= side_in;
			ch_s2 <= a_s1[55:32] * cm_s1;
			sh_s2 <= a_s1[55:32] * sm_s1;
			cl_s2 <= a_s1[31:0] * cm_s1;
			sl_s2 <= a_s1[31:0] * sm_s1;
			nc_s2 <= nc_s1;
			ns_s2 <= ns_s1;
			sd_s2 <= sd_s1;
		end
	end

	logic [63:0] cr, sr;
	logic [49:0] mc, ms;
	logic signed [51:0] dxs, dys;
	logic signed [51:0] sx, sy;
	always_comb begin
		cr  = cl_s2 + (64'd1 << 45);
		sr  = sl_s2 + (64'd1 << 45);
		mc  = 50'((64'(ch_s2) + (cr >> 32)) >> 14);
		ms  = 50'((64'(sh_s2) + (sr >> 32)) >> 14);
		dxs = nc_s2 ? -52'(mc) : 52'(mc);
		dys = ns_s2 ? -52'(ms) : 52'(ms);
		sx  = 52'(sd_s2.px) + dxs;
		sy  = 52'(sd_s2.py) + dys;
	end

	function automatic logic [31:0] sat52(input logic signed [51:0] v);
		if (v > 52'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (v < -52'sh80000000) return 32'h80000000;
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= {sd_s2.nturn, sd_s2.nspeed,
				sat52(52'(sd_s2.th) + 52'(sd_s2.hstep)),
				sat52(sy), sat52(sx)};
		end
	end
endmodule
`default_nettype wire

// ===== sv/unicycle_pose_predict.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 3 + CordicStages + 3 register stages, that is 22 stages at 16
// CORDIC stages.
// Throughput: one request per cycle; the whole pipe stalls only when the
// output is held and the output register is full.
// Reset: arst_n clears all valid flags at once; payload is not reset.
// ----------------------------------------------------------------------------
// unicycle_pose_predict: unicycle motion predict step
// Reduction front, chain of CORDIC cells, scaling back end.
// ----------------------------------------------------------------------------
module unicycle_pose_predict (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pose_x, pose_y, heading, speed, turn_rate, time_step, command_valid,
	// command_speed, command_turn_rate, zero pad
	input  wire logic [255:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// next_x, next_y, next_heading, next_speed, next_turn_rate
	output logic [159:0]      m_tdata
);
	localparam int N = upp_pkg::CordicStages;

	logic en;
	logic          v_f;
	upp_pkg::rot_t r_f;
	upp_pkg::side_t d_f;
	logic          vc [N+1];
	upp_pkg::rot_t rc [N+1];
	upp_pkg::side_t dc [N+1];

	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;

	upp_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(s_tvalid), .req(s_tdata[248:0]),
		.vld_q(v_f), .rot_q(r_f), .side_q(d_f)
	);

	assign vc[0] = v_f;
	assign rc[0] = r_f;
	assign dc[0] = d_f;

	for (genvar g = 0; g < N; g++) begin : g_cell
		upp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.stage(upp_pkg::StageW'(g)),
			.vld_in(vc[g]), .rot_in(rc[g]), .side_in(dc[g]),
			.vld_q(vc[g+1]), .rot_q(rc[g+1]), .side_q(dc[g+1])
		);
	end

	upp_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vc[N]), .rot_in(rc[N]), .side_in(dc[N]),
		.vld_q(m_tvalid), .res_q(m_tdata)
	);

	logic unused;
	assign unused = ^s_tdata[255:249];
endmodule
`default_nettype wire

// ===== sv/upp_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upp_check: port checker for the pose predictor
// Watches the stream handshakes over time.
// ----------------------------------------------------------------------------
module upp_check (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [159:0] m_tdata
);
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	ap_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");
	ap_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");
endmodule

bind unicycle_pose_predict upp_check u_upp_check (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
